// ===== rtl/event_log_ring_time_query_macros.svh =====
// Assertion helpers for the event log RTL.
`ifndef EVENT_LOG_RING_TIME_QUERY_MACROS_SVH
`define EVENT_LOG_RING_TIME_QUERY_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ELRTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("elrtq same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define ELRTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("elrtq next-cycle check failed");
`else
`define ELRTQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ELRTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/elrtq_pkg.sv =====
`default_nettype none

package elrtq_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // One input word.
    typedef struct packed {
        logic [1:0]  operation;
        logic [23:0] object_address;
        logic        point_value;
        logic [7:0]  quality_bits;
        logic [63:0] event_time;
        logic [63:0] window_begin;
        logic [63:0] window_end;
        logic [6:0]  result_limit;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic        record_found;
        logic [23:0] out_address;
        logic        out_value;
        logic [7:0]  out_quality;
        logic [63:0] out_time;
        logic [31:0] out_sequence;
        logic [6:0]  stored_count;
        logic        last_result;
    } t_out_word;

    // One stored log record.
    typedef struct packed {
        logic [23:0] address;
        logic        value;
        logic [7:0]  quality;
        logic [63:0] stamp;
        logic [31:0] seq_num;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/event_log_ring_time_query.sv =====
// Circular event log with a time window query.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one word per
// operation: append, query or clear. Output channel (o_out_valid /
// i_out_ready / o_out_data) gives result words from a single output register.
// Append, clear and an unknown operation each give one word.
// A query reads the log RAM once per stored record, oldest first, through one
// read port and one shared window comparator, and it gives one word per
// matching record up to the limit, or one empty word if nothing matched.
// Each match is held in a register so that the final one can carry the
// last flag.
// The input side is ready only when the sequencer is idle and the output
// register is free or being emptied in the same cycle.
// When the receiver stalls, the walk pauses on the pending match and the RAM
// read data holds; nothing is lost or repeated.
// Reset empties the log and restarts the sequence numbering at one; the
// record RAM itself is not cleared, since only written slots are ever read.
`default_nettype none

`include "event_log_ring_time_query_macros.svh"

module event_log_ring_time_query #(
    parameter int LOG_DEPTH = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire elrtq_pkg::t_in_word  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output elrtq_pkg::t_out_word      o_out_data
);

    import elrtq_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_wp, n_wp;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_seq, n_seq;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_remain, n_remain;
    logic [CW-1:0]    r_found, n_found;
    logic             r_pend, n_pend;
    logic             r_hold_valid, n_hold_valid;
    t_out_word        r_hold, n_hold;
    logic [63:0]      r_begin, n_begin;
    logic [63:0]      r_end, n_end;
    logic [6:0]       r_limit, n_limit;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    logic             w_accept;
    logic             w_out_free;
    logic             w_match;
    logic             w_stall;
    logic             w_issue;
    logic [CW-1:0]    w_found_next;
    logic [CW:0]      w_start_sum;
    logic [AW-1:0]    w_start;
    logic [31:0]      w_seq_inc;
    logic [CW-1:0]    w_count_inc;
    logic             w_we;
    t_entry           w_wdata;
    t_entry           w_rdata;
    logic             w_push;
    t_out_word        w_push_data;
    t_out_word        w_empty;

    // Record storage.
    elrtq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_re    (w_issue),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Shared window comparator on the record just read.
    elrtq_window u_window (
        .i_stamp (w_rdata.stamp),
        .i_begin (r_begin),
        .i_end   (r_end),
        .o_match (w_match)
    );

    // Handshake and walk helpers.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_seq_inc    = r_seq + 32'd1;
    assign w_count_inc  = (r_count == CW'(LOG_DEPTH)) ? r_count : r_count + CW'(1);
    assign w_start_sum  = (CW+1)'(r_wp) + (CW+1)'(LOG_DEPTH) - (CW+1)'(r_count);
    assign w_start      = (w_start_sum >= (CW+1)'(LOG_DEPTH)) ?
                          AW'(w_start_sum - (CW+1)'(LOG_DEPTH)) : AW'(w_start_sum);

    assign w_stall      = (r_state == S_WALK) && r_pend && w_match && r_hold_valid &&
                          !w_out_free;
    assign w_found_next = r_found + CW'(r_pend && w_match);
    assign w_issue      = (r_state == S_WALK) && !w_stall && (r_remain != '0) &&
                          (7'(w_found_next) < r_limit);

    assign w_we = w_accept && (i_in_data.operation == OP_APPEND);
    always_comb begin
        w_wdata.address  = i_in_data.object_address;
        w_wdata.value    = i_in_data.point_value;
        w_wdata.quality  = i_in_data.quality_bits;
        w_wdata.stamp    = i_in_data.event_time;
        w_wdata.seq_num  = w_seq_inc;
    end

    // An empty result word with the current count.
    always_comb begin
        w_empty              = '0;
        w_empty.stored_count = 7'(r_count);
        w_empty.last_result  = 1'b1;
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_count      = r_count;
        n_seq        = r_seq;
        n_idx        = r_idx;
        n_remain     = r_remain;
        n_found      = r_found;
        n_pend       = r_pend;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_begin      = r_begin;
        n_end        = r_end;
        n_limit      = r_limit;
        w_push       = 1'b0;
        w_push_data  = w_empty;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.operation)
                        OP_APPEND: begin
                            n_seq   = w_seq_inc;
                            n_wp    = (r_wp == AW'(LOG_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                            n_count = w_count_inc;
                            w_push  = 1'b1;
                            w_push_data.out_sequence = w_seq_inc;
                            w_push_data.stored_count = 7'(w_count_inc);
                        end
                        OP_CLEAR: begin
                            n_seq   = '0;
                            n_wp    = '0;
                            n_count = '0;
                            w_push  = 1'b1;
                            w_push_data.stored_count = 7'd0;
                        end
                        OP_QUERY: begin
                            n_begin      = i_in_data.window_begin;
                            n_end        = i_in_data.window_end;
                            n_limit      = i_in_data.result_limit;
                            n_idx        = w_start;
                            n_remain     = r_count;
                            n_found      = '0;
                            n_pend       = 1'b0;
                            n_hold_valid = 1'b0;
                            n_state      = S_WALK;
                        end
                        default: begin
                            w_push = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (!w_stall) begin
                    // A new match replaces the held one, which goes out as non-final.
                    if (r_pend && w_match) begin
                        n_hold.record_found = 1'b1;
                        n_hold.out_address  = w_rdata.address;
                        n_hold.out_value    = w_rdata.value;
                        n_hold.out_quality  = w_rdata.quality;
                        n_hold.out_time     = w_rdata.stamp;
                        n_hold.out_sequence = w_rdata.seq_num;
                        n_hold.stored_count = 7'(r_count);
                        n_hold.last_result  = 1'b0;
                        n_hold_valid        = 1'b1;
                        n_found             = w_found_next;
                        if (r_hold_valid) begin
                            w_push      = 1'b1;
                            w_push_data = r_hold;
                        end
                    end
                    n_pend = w_issue;
                    if (w_issue) begin
                        n_idx    = (r_idx == AW'(LOG_DEPTH - 1)) ? '0 : r_idx + AW'(1);
                        n_remain = r_remain - CW'(1);
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_push = 1'b1;
                    if (r_hold_valid) begin
                        w_push_data             = r_hold;
                        w_push_data.last_result = 1'b1;
                    end
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_push) begin
            n_out_valid = 1'b1;
            n_out       = w_push_data;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wp         <= '0;
            r_count      <= '0;
            r_seq        <= '0;
            r_pend       <= 1'b0;
            r_hold_valid <= 1'b0;
            r_found      <= '0;
            r_remain     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wp         <= n_wp;
            r_count      <= n_count;
            r_seq        <= n_seq;
            r_pend       <= n_pend;
            r_hold_valid <= n_hold_valid;
            r_found      <= n_found;
            r_remain     <= n_remain;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_hold  <= n_hold;
        r_begin <= n_begin;
        r_end   <= n_end;
        r_limit <= n_limit;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks on the sequencer.
    `ELRTQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(LOG_DEPTH))
    `ELRTQ_ASSERT_NOW(a_found_limit, i_clk, i_rst_n, r_state == S_WALK, 7'(r_found) <= r_limit)
    `ELRTQ_ASSERT_NOW(a_hold_found, i_clk, i_rst_n, r_hold_valid, r_found != '0)
    `ELRTQ_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_accept && (i_in_data.operation == OP_CLEAR), (r_count == '0) && (r_seq == '0) && (r_wp == '0))
    `ELRTQ_ASSERT_NEXT(a_append_seq, i_clk, i_rst_n, w_accept && (i_in_data.operation == OP_APPEND), r_seq == $past(r_seq) + 32'd1)

endmodule

`default_nettype wire

// ===== rtl/elrtq_ram.sv =====
`default_nettype none

module elrtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds when idle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/elrtq_window.sv =====
`default_nettype none

module elrtq_window (
    input  wire logic [63:0] i_stamp,
    input  wire logic [63:0] i_begin,
    input  wire logic [63:0] i_end,
    output logic             o_match
);

    logic w_lo_ok;
    logic w_hi_ok;

    // A zero bound leaves that side of the window open.
    assign w_lo_ok = (i_begin == 64'd0) || (i_stamp >= i_begin);
    assign w_hi_ok = (i_end == 64'd0) || (i_stamp <= i_end);
    assign o_match = w_lo_ok && w_hi_ok;

endmodule

`default_nettype wire
